/* hdl/mcc_pkg.sv */
// mcc_pkg: types, constants and the crc-16 byte update for the message check block
// no dependencies
`default_nettype none
package mcc_pkg;

  localparam int MAX_BYTES    = 8;
  localparam int NUM_CHANNELS = 2;

  localparam int CH_W     = 1;
  localparam int CH_SLOTS = 2 ** CH_W;
  localparam int RC_W     = 4;
  localparam int CRC_W    = 16;
  localparam int CNT_W    = $clog2(MAX_BYTES + 1);

  localparam logic [CRC_W-1:0] CRC_POLY = 16'h1021;
  localparam logic [CRC_W-1:0] CRC_INIT = 16'hFFFF;

  localparam int Q_DEPTH = 2;
  localparam int Q_AW    = $clog2(Q_DEPTH);
  localparam int Q_CW    = $clog2(Q_DEPTH + 1);

  typedef struct packed {
    logic [CH_W-1:0]  channel;
    logic [7:0]       data_byte;
    logic             last_byte;
    logic [RC_W-1:0]  rx_counter;
    logic [CRC_W-1:0] rx_crc;
  } in_t;

  typedef struct packed {
    logic [CH_W-1:0] out_channel;
    logic [7:0]      value;
    logic            valid_res;
    logic            crc_match;
    logic            counter_match;
  } out_t;

  typedef struct packed {
    logic [CH_W-1:0] channel;
    logic [7:0]      first_byte;
    logic            crc_match;
    logic [RC_W-1:0] rx_counter;
  } msg_t;

  function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc_in,
                                                input logic [7:0] b);
    logic [CRC_W-1:0] c;
    c = crc_in ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[CRC_W-1]) begin
        c = {c[CRC_W-2:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[CRC_W-2:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage
`default_nettype wire

/* hdl/message_crc_counter_check.sv */
// message_crc_counter_check: top level, front crc stage, message queue and checking back end
// depends on mcc_pkg, mcc_front, mcc_msg_fifo, mcc_back
//
// Takes one message byte per request at up to one request per clock; the front runs an
// 8-bit parallel CRC-16/CCITT-FALSE update on each accepted byte of the first MAX_BYTES, and
// on the last byte the message goes through a two-entry queue to the back end, which checks
// the per-channel rolling counter. A message is registered in the queue, its verdict in the
// back end's verdict queue, which holds it on out_ until popped; both sides stall on their own.
`default_nettype none
module message_crc_counter_check (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_push,
  input  mcc_pkg::in_t  in_data,
  output logic          in_full,
  output logic          out_empty,
  input  wire logic     out_pop,
  output mcc_pkg::out_t out_data
);
  import mcc_pkg::*;

  logic msg_push, msg_full, msg_pop, msg_empty;
  msg_t msg_wdata, msg_rdata;

  mcc_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_data  (in_data),
    .in_full  (in_full),
    .msg_push (msg_push),
    .msg_data (msg_wdata),
    .msg_full (msg_full)
  );

  mcc_msg_fifo u_msg_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (msg_push),
    .wdata (msg_wdata),
    .full  (msg_full),
    .pop   (msg_pop),
    .empty (msg_empty),
    .rdata (msg_rdata)
  );

  mcc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .msg_empty (msg_empty),
    .msg_data  (msg_rdata),
    .msg_pop   (msg_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

/* hdl/mcc_msg_fifo.sv */
// mcc_msg_fifo: short queue of finished messages between front and back
// depends on mcc_pkg
`default_nettype none
module mcc_msg_fifo (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  mcc_pkg::msg_t      wdata,
  output logic               full,
  input  wire logic          pop,
  output logic               empty,
  output mcc_pkg::msg_t      rdata
);
  import mcc_pkg::*;

  msg_t             mem_r [Q_DEPTH];
  logic [Q_AW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [Q_AW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [Q_CW-1:0]  count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == Q_CW'(Q_DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= Q_CW'(Q_DEPTH))
    else $error("message queue count beyond depth");

endmodule
`default_nettype wire

/* hdl/mcc_front.sv */
// mcc_front: takes byte requests, runs the crc-16 and hands finished messages on
// depends on mcc_pkg
`default_nettype none
module mcc_front (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_push,
  input  mcc_pkg::in_t  in_data,
  output logic          in_full,
  output logic          msg_push,
  output mcc_pkg::msg_t msg_data,
  input  wire logic     msg_full
);
  import mcc_pkg::*;

  logic [CRC_W-1:0] crc_r, crc_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [7:0]       fb_r, fb_nxt;
  logic             acc, take;
  logic [CRC_W-1:0] crc_cur;
  logic [7:0]       fb_cur;

  assign in_full = msg_full;
  assign acc     = in_push && !in_full;
  assign take    = (cnt_r < CNT_W'(MAX_BYTES));
  assign crc_cur = take ? crc_byte(crc_r, in_data.data_byte) : crc_r;
  assign fb_cur  = (cnt_r == '0) ? in_data.data_byte : fb_r;

  always_comb begin
    crc_nxt = crc_r;
    cnt_nxt = cnt_r;
    fb_nxt  = fb_r;
    if (acc) begin
      if (in_data.last_byte) begin
        crc_nxt = CRC_INIT;
        cnt_nxt = '0;
        fb_nxt  = '0;
      end else begin
        crc_nxt = crc_cur;
        cnt_nxt = take ? cnt_r + 1'b1 : cnt_r;
        fb_nxt  = fb_cur;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r <= CRC_INIT;
      cnt_r <= '0;
      fb_r  <= '0;
    end else begin
      crc_r <= crc_nxt;
      cnt_r <= cnt_nxt;
      fb_r  <= fb_nxt;
    end
  end

  assign msg_push            = acc && in_data.last_byte;
  assign msg_data.channel    = in_data.channel;
  assign msg_data.first_byte = fb_cur;
  assign msg_data.crc_match  = (crc_cur == in_data.rx_crc);
  assign msg_data.rx_counter = in_data.rx_counter;

  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    msg_push |=> (cnt_r == '0) && (crc_r == CRC_INIT))
    else $error("message state not cleared after last byte");

endmodule
`default_nettype wire

/* hdl/mcc_back.sv */
// mcc_back: checks rolling counters per channel and queues verdicts for the output
// depends on mcc_pkg
`default_nettype none
module mcc_back (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     msg_empty,
  input  mcc_pkg::msg_t msg_data,
  output logic          msg_pop,
  output logic          out_empty,
  input  wire logic     out_pop,
  output mcc_pkg::out_t out_data
);
  import mcc_pkg::*;

  logic [RC_W-1:0] exp_r [CH_SLOTS];
  out_t            oq_r [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [Q_CW-1:0] count_r, count_nxt;
  logic            in_range, cnt_ok, ok, do_pop;
  out_t            res;

  assign msg_pop  = !msg_empty && (count_r != Q_CW'(Q_DEPTH));
  assign in_range = (int'(msg_data.channel) < NUM_CHANNELS);
  assign cnt_ok   = in_range && (msg_data.rx_counter == exp_r[msg_data.channel]);
  assign ok       = msg_data.crc_match && cnt_ok;

  assign res.out_channel   = msg_data.channel;
  assign res.value         = ok ? msg_data.first_byte : '0;
  assign res.valid_res     = ok;
  assign res.crc_match     = msg_data.crc_match;
  assign res.counter_match = cnt_ok;

  assign out_empty = (count_r == '0);
  assign do_pop    = out_pop && !out_empty;
  assign out_data  = oq_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (msg_pop && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !msg_pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
      for (int c = 0; c < CH_SLOTS; c++) begin
        exp_r[c] <= '0;
      end
    end else begin
      count_r <= count_nxt;
      if (msg_pop) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (msg_pop && ok) begin
        exp_r[msg_data.channel] <= exp_r[msg_data.channel] + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (msg_pop) begin
      oq_r[wr_ptr_r] <= res;
    end
  end

  a_valid_needs_both: assert property (@(posedge clk) disable iff (!rst_n)
    (msg_pop && res.valid_res) |-> (res.crc_match && res.counter_match))
    else $error("valid verdict without both matches");

  a_counter_kept: assert property (@(posedge clk) disable iff (!rst_n)
    !(msg_pop && ok) |=> ($stable(exp_r[0]) && $stable(exp_r[1])))
    else $error("rolling counter moved without a valid message");

  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= Q_CW'(Q_DEPTH))
    else $error("verdict queue count beyond depth");

endmodule
`default_nettype wire

/* test/tb_message_crc_counter_check.sv */
// tb_message_crc_counter_check: self-checking bench for the crc-16 / alive counter message check
// depends on mcc_pkg and message_crc_counter_check; a verdict board predicts and compares each
// verdict while plain tasks drive directed and random messages under varying back pressure
`timescale 1ns / 1ps
module tb_message_crc_counter_check;
  import mcc_pkg::*;

  localparam int RUN_LIMIT    = 400000;
  localparam int DRAIN_CYCLES = 8;
  localparam int TARGET_BYTES = 1300;
  localparam int MAX_LEN      = 20;

  typedef enum int {MSG_GOOD, MSG_BAD_CRC, MSG_BAD_COUNT, MSG_BAD_BOTH, MSG_NOISE} msg_kind_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_push = 1'b0;
  in_t in_data = '0;
  logic in_full;
  logic out_empty;
  logic out_pop = 1'b0;
  out_t out_data;

  int in_gap_pct = 0;
  int out_stall_pct = 0;
  int hold_left = 0;
  int bytes_sent = 0;
  int cycles = 0;

  message_crc_counter_check dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_data   (in_data),
    .in_full   (in_full),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data)
  );

  // msb-first crc-16, one data bit folded into the feedback per shift
  function automatic logic [CRC_W-1:0] crc16_step(logic [CRC_W-1:0] acc, logic [7:0] b);
    logic fb;
    for (int i = 7; i >= 0; i--) begin
      fb = acc[CRC_W-1] ^ b[i];
      acc = {acc[CRC_W-2:0], 1'b0} ^ (fb ? CRC_POLY : '0);
    end
    return acc;
  endfunction

  class verdict_board_t;
    logic [CRC_W-1:0] crc_acc;
    int unsigned taken;
    logic [7:0] head;
    logic [RC_W-1:0] alive[CH_SLOTS];
    out_t pending[$];
    int errors;
    int verdicts_seen;
    int valid_seen;

    function new();
      crc_acc = CRC_INIT;
      taken = 0;
      head = '0;
      foreach (alive[c]) alive[c] = '0;
      errors = 0;
      verdicts_seen = 0;
      valid_seen = 0;
    endfunction

    function void note_request(in_t r);
      logic crc_ok;
      logic cnt_ok;
      out_t v;
      if (taken == 0) head = r.data_byte;
      if (taken < MAX_BYTES) begin
        crc_acc = crc16_step(crc_acc, r.data_byte);
        taken++;
      end
      if (r.last_byte) begin
        crc_ok = (crc_acc == r.rx_crc);
        cnt_ok = (r.channel < NUM_CHANNELS) && (r.rx_counter == alive[r.channel]);
        v.out_channel = r.channel;
        v.valid_res = crc_ok && cnt_ok;
        v.value = v.valid_res ? head : 8'h00;
        v.crc_match = crc_ok;
        v.counter_match = cnt_ok;
        if (v.valid_res) alive[r.channel] = alive[r.channel] + 1'b1;
        pending.push_back(v);
        crc_acc = CRC_INIT;
        taken = 0;
        head = '0;
      end
    endfunction

    task report_mismatch(string what, int unsigned got, int unsigned want);
      $display("%0t mismatch %s: got %0h, want %0h", $time, what, got, want);
      errors++;
    endtask

    task check_verdict(out_t got);
      out_t want;
      if (pending.size() == 0) begin
        report_mismatch("verdict with none pending", got, 0);
      end else begin
        want = pending.pop_front();
        verdicts_seen++;
        if (want.valid_res) valid_seen++;
        if (got.out_channel !== want.out_channel)
          report_mismatch("out_channel", got.out_channel, want.out_channel);
        if (got.value !== want.value) report_mismatch("value", got.value, want.value);
        if (got.valid_res !== want.valid_res)
          report_mismatch("valid_res", got.valid_res, want.valid_res);
        if (got.crc_match !== want.crc_match)
          report_mismatch("crc_match", got.crc_match, want.crc_match);
        if (got.counter_match !== want.counter_match)
          report_mismatch("counter_match", got.counter_match, want.counter_match);
      end
    endtask
  endclass

  verdict_board_t board;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= RUN_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // result side: check popped verdicts, then pick the next pop
  always @(posedge clk) begin
    if (rst_n && out_pop && out_empty === 1'b0) board.check_verdict(out_data);
    if (hold_left > 0) begin
      out_pop <= 1'b0;
      hold_left = hold_left - 1;
    end else begin
      out_pop <= ($urandom_range(99) >= out_stall_pct);
    end
  end

  task automatic push_request(in_t r);
    while ($urandom_range(99) < in_gap_pct) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_push <= 1'b1;
    in_data <= r;
    @(posedge clk);
    while (in_full !== 1'b0) @(posedge clk);
    board.note_request(r);
    bytes_sent++;
  endtask

  task automatic send_message(logic [CH_W-1:0] ch, int len, msg_kind_t kind, bit mix_ch,
                              int fill);
    logic [7:0] body[32];
    logic [CRC_W-1:0] crc;
    in_t r;
    crc = CRC_INIT;
    for (int i = 0; i < len; i++) begin
      body[i] = (fill < 0) ? 8'($urandom_range(255)) : fill[7:0];
      if (i < MAX_BYTES) crc = crc16_step(crc, body[i]);
    end
    for (int i = 0; i < len; i++) begin
      r.channel = (mix_ch && i != len - 1) ? CH_W'($urandom_range(CH_SLOTS - 1)) : ch;
      r.data_byte = body[i];
      r.last_byte = (i == len - 1);
      r.rx_counter = RC_W'($urandom_range(15));
      r.rx_crc = CRC_W'($urandom_range(16'hFFFF));
      if (r.last_byte) begin
        r.rx_counter = board.alive[ch];
        r.rx_crc = crc;
        case (kind)
          MSG_BAD_CRC: begin
            r.rx_crc = crc ^ (16'h0001 << $urandom_range(15));
          end
          MSG_BAD_COUNT: begin
            r.rx_counter = board.alive[ch] + RC_W'($urandom_range(1, 15));
          end
          MSG_BAD_BOTH: begin
            r.rx_crc = crc ^ (16'h0001 << $urandom_range(15));
            r.rx_counter = board.alive[ch] + RC_W'($urandom_range(1, 15));
          end
          MSG_NOISE: begin
            r.rx_counter = RC_W'($urandom_range(15));
            r.rx_crc = CRC_W'($urandom_range(16'hFFFF));
          end
          default: begin
          end
        endcase
      end
      push_request(r);
    end
  endtask

  task automatic random_message();
    int pick;
    int len;
    msg_kind_t kind;
    pick = $urandom_range(99);
    if (pick < 70) kind = MSG_GOOD;
    else if (pick < 80) kind = MSG_BAD_CRC;
    else if (pick < 88) kind = MSG_BAD_COUNT;
    else if (pick < 93) kind = MSG_BAD_BOTH;
    else kind = MSG_NOISE;
    len = ($urandom_range(99) < 85) ? $urandom_range(1, MAX_BYTES)
                                    : $urandom_range(MAX_BYTES + 1, MAX_LEN);
    send_message(CH_W'($urandom_range(CH_SLOTS - 1)), len, kind, $urandom_range(9) == 0, -1);
  endtask

  task automatic run_phase(int goal);
    while (bytes_sent < goal) random_message();
  endtask

  // stop offering requests, then wait for every expected verdict
  task automatic wait_drained();
    in_push <= 1'b0;
    @(posedge clk);
    while (board.pending.size() != 0) @(posedge clk);
  endtask

  initial begin
    board = new();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: byte extremes, full and overlong messages, both failure kinds, channel switch
    send_message(0, 1, MSG_GOOD, 1'b0, 8'h00);
    send_message(1, 1, MSG_GOOD, 1'b0, 8'hFF);
    send_message(0, MAX_BYTES, MSG_GOOD, 1'b0, -1);
    send_message(1, MAX_BYTES + 2, MSG_GOOD, 1'b0, -1);
    send_message(0, 1, MSG_BAD_CRC, 1'b0, 8'hA5);
    send_message(1, 1, MSG_BAD_COUNT, 1'b0, 8'h5A);
    send_message(CH_W'(CH_SLOTS - 1), 2, MSG_GOOD, 1'b1, -1);
    wait_drained();

    in_gap_pct = 15;
    out_stall_pct = 81;
    run_phase(bytes_sent + 430);
    wait_drained();

    in_gap_pct = 81;
    out_stall_pct = 15;
    run_phase(bytes_sent + 430);
    wait_drained();

    // long receiver hold-off while short messages pile up behind it
    in_gap_pct = 0;
    out_stall_pct = 0;
    hold_left = 200;
    repeat (16) send_message(CH_W'($urandom_range(CH_SLOTS - 1)), 1, MSG_GOOD, 1'b0, -1);
    run_phase(TARGET_BYTES);

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.pending.size() != 0)
      board.report_mismatch("verdicts never delivered", 0, board.pending.size());
    $display("sent %0d bytes, checked %0d verdicts (%0d valid) over three stall mixes",
             bytes_sent, board.verdicts_seen, board.valid_seen);
    if (board.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
